### design/fed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types, constants and arithmetic helpers of the feedback echo delay.
// ----------------------------------------------------------------------------
package fed_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DLY_W      = 15;
  localparam int GAIN_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
  localparam int SCALED_W   = PROD_W - 15;
  localparam int SUM_W      = SCALED_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SAMPLE_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -SUM_W'(8388608);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_ECHO     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_channel;
  } out_t;

  // Status of the delay reduction unit
  typedef struct packed {
    logic busy;
    logic on;
  } dly_stat_t;

  // Scale a Q1.15 gain product: round to nearest, ties toward plus infinity
  function automatic logic signed [SCALED_W-1:0] scale_q15(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] t;
    t = p + ROUND_HALF;
    return t[PROD_W-1:15];
  endfunction

  // Clamp a sum to the signed 24-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] c;
    if (v > SAMPLE_MAX) begin
      c = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      c = SAMPLE_MIN;
    end else begin
      c = v;
    end
    return c[SAMPLE_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/fed_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fed_ram #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/fed_dly_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_dly_mod
// Reduces a newly written delay modulo the line depth by reciprocal
// multiplication and subtraction, and holds the result as the read-back offset.
// ----------------------------------------------------------------------------
module fed_dly_mod
  import fed_pkg::*;
#(
  parameter int LINE_DEPTH = 32768,
  parameter int PTR_W      = $clog2(LINE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DLY_W-1:0] delay_in,
  output logic      [PTR_W-1:0] back,
  output dly_stat_t             stat
);

  // Quotient by ceil(2^SHIFT / depth) is exact for every 15-bit delay
  localparam int     LOG_D = $clog2(LINE_DEPTH);
  localparam int     SHIFT = DLY_W + LOG_D;
  localparam int     M_W   = DLY_W + 2;
  localparam int     MUL_W = (SHIFT + 1 > DLY_W + M_W) ? SHIFT + 1 : DLY_W + M_W;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(LINE_DEPTH) - 1)
                             / longint'(LINE_DEPTH);
  localparam logic [M_W-1:0]   RECIP_V  = M_W'(RECIP);
  localparam logic [DLY_W-1:0] DEPTH_LO = DLY_W'(LINE_DEPTH);

  logic [DLY_W-1:0] dly;
  logic [MUL_W-1:0] prod;
  logic [DLY_W-1:0] quot;
  logic [DLY_W-1:0] rem;
  logic             mul_pend;
  logic             sub_pend;
  logic             on;

  assign quot = DLY_W'(prod >> SHIFT);

  // Load on a write, multiply by the reciprocal, then subtract quotient times depth
  always_ff @(posedge clk) begin
    if (rst) begin
      dly      <= '0;
      prod     <= '0;
      rem      <= '0;
      mul_pend <= 1'b0;
      sub_pend <= 1'b0;
      on       <= 1'b0;
    end else if (start) begin
      dly      <= delay_in;
      mul_pend <= 1'b1;
      sub_pend <= 1'b0;
      on       <= (delay_in != '0);
    end else begin
      mul_pend <= 1'b0;
      sub_pend <= mul_pend;
      if (mul_pend) begin
        prod <= MUL_W'(dly) * MUL_W'(RECIP_V);
      end
      if (sub_pend) begin
        rem <= dly - DLY_W'(quot * DEPTH_LO);
      end
    end
  end

  assign back      = PTR_W'(rem);
  assign stat.busy = mul_pend || sub_pend;
  assign stat.on   = on;

endmodule
`default_nettype wire

### design/fed_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fed_fifo
// Small result queue between the processing pipeline and the output channel.
// ----------------------------------------------------------------------------
module fed_fifo
  import fed_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire out_t               push_data,
  input  wire logic               pop,
  output out_t                    head,
  output logic      [FIFO_CW-1:0] count
);

  out_t             slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = slots[rd_ptr];

endmodule
`default_nettype wire

### design/feedback_echo_delay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Multichannel feedback echo built around one delay-line memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one Q1.23 sample with its
// channel index per transaction; output channel (out_valid/out_ready/out_data)
// returns one processed sample per input, in input order.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 delay,
// 1 feedback gain, 2 echo gain) with no wait.
// An accepted sample passes stage 1 and stage 2, then enters the result
// queue, whose fill raises out_valid. Throughput: one sample per cycle while
// in_ready stays high; when the delay is congruent to one modulo LINE_DEPTH,
// in_ready drops while a sample sits in stage 1, so the value stored by one
// sample is read by the very next one through the write-back register.
// A write of delay_samples is reduced modulo LINE_DEPTH by fed_dly_mod,
// during which in_ready is low.
// Reset: configuration, position and valid registers go to zero; a clearing
// pass writes zero to all CHANNELS * LINE_DEPTH line entries (65536 by default)
// with in_ready low; configuration writes are taken meanwhile.
// Stall: results wait in a four-entry queue; in_ready drops once the queue
// plus the samples in flight would fill it, so nothing is lost.
// ----------------------------------------------------------------------------
module feedback_echo_delay
  import fed_pkg::*;
#(
  parameter int LINE_DEPTH = 32768,
  parameter int CHANNELS   = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int PTR_W     = $clog2(LINE_DEPTH);
  localparam int MEM_DEPTH = CHANNELS * LINE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Configuration
  logic [GAIN_W-1:0] fb_gain;
  logic [GAIN_W-1:0] echo_gain;
  logic              dly_start;
  logic [PTR_W-1:0]  back;
  dly_stat_t         dly_stat;
  logic              back_one;

  // Clearing pass
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  // Accept stage
  logic              accept;
  logic              ch_ok;
  logic              in_active;
  logic [PTR_W-1:0]  wpos [2];
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_next;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] in_raddr;
  logic [ADDR_W-1:0] in_waddr;

  // Stage 1: delayed value and gain products
  logic                       s1_valid;
  logic                       s1_active;
  logic                       s1_ch;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [ADDR_W-1:0]          s1_raddr;
  logic [ADDR_W-1:0]          s1_waddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic signed [SAMPLE_W-1:0] d;
  logic signed [PROD_W-1:0]   pf;
  logic signed [PROD_W-1:0]   pe;

  // Stage 2: round, add, saturate
  logic                       s2_valid;
  logic                       s2_active;
  logic                       s2_ch;
  logic signed [SAMPLE_W-1:0] s2_x;
  logic [ADDR_W-1:0]          s2_waddr;
  logic signed [PROD_W-1:0]   s2_pf;
  logic signed [PROD_W-1:0]   s2_pe;
  logic signed [SUM_W-1:0]    fb_sum;
  logic signed [SUM_W-1:0]    echo_diff;
  logic signed [SAMPLE_W-1:0] store_val;
  logic signed [SAMPLE_W-1:0] y;

  // Write-back register for forwarding
  logic                w_valid;
  logic [ADDR_W-1:0]   w_addr;
  logic [SAMPLE_W-1:0] w_data;

  // Memory write port
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [SAMPLE_W-1:0] mem_wdata;

  // Result queue
  out_t               res;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW:0]   occupancy;

  // Capture gain registers; the delay goes to the reduction unit
  always_ff @(posedge clk) begin
    if (rst) begin
      fb_gain   <= '0;
      echo_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FEEDBACK: fb_gain   <= cfg_data;
        REG_ECHO:     echo_gain <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign dly_start = cfg_we && (cfg_reg_t'(cfg_index) == REG_DELAY);

  fed_dly_mod #(
    .LINE_DEPTH (LINE_DEPTH),
    .PTR_W      (PTR_W)
  ) u_dly_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (dly_start),
    .delay_in (cfg_data[DLY_W-1:0]),
    .back     (back),
    .stat     (dly_stat)
  );

  assign back_one = (back == PTR_W'(1));

  // Sweep the line with zeros after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Flow control: hold input while busy, on a back-to-back read of the
  // previous write, or when the queue could not take every sample in flight
  assign occupancy = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(s1_valid)
                   + (FIFO_CW + 1)'(s2_valid);
  assign in_ready  = !clr_busy && !dly_stat.busy && !(back_one && s1_valid)
                   && (occupancy < (FIFO_CW + 1)'(FIFO_DEPTH));
  assign accept    = in_valid && in_ready;

  // Read and write positions of the incoming sample
  always_comb begin
    ch_ok     = (CHANNELS > 1) || !in_data.channel;
    in_active = dly_stat.on && ch_ok;
    wp        = wpos[in_data.channel];
    rp        = wp - back;
    if (wp < back) begin
      rp = rp + PTR_W'(LINE_DEPTH);
    end
    wp_next   = (wp == PTR_W'(LINE_DEPTH - 1)) ? '0 : wp + 1'b1;
    base      = in_data.channel ? ADDR_W'(LINE_DEPTH) : '0;
    in_raddr  = base + ADDR_W'(rp);
    in_waddr  = base + ADDR_W'(wp);
  end

  // Advance the channel's write position on an active transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos[0] <= '0;
      wpos[1] <= '0;
    end else if (accept && in_active) begin
      wpos[in_data.channel] <= wp_next;
    end
  end

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      w_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      w_valid  <= s2_valid && s2_active;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_active <= in_active;
    s1_ch     <= in_data.channel;
    s1_x      <= in_data.sample_in;
    s1_raddr  <= in_raddr;
    s1_waddr  <= in_waddr;
    s2_active <= s1_active;
    s2_ch     <= s1_ch;
    s2_x      <= s1_x;
    s2_waddr  <= s1_waddr;
    s2_pf     <= pf;
    s2_pe     <= pe;
    w_addr    <= s2_waddr;
    w_data    <= store_val;
  end

  // Memory write port: clearing pass or write-back of the new line value
  assign mem_we    = clr_busy || (s2_valid && s2_active);
  assign mem_waddr = clr_busy ? clr_addr : s2_waddr;
  assign mem_wdata = clr_busy ? '0 : store_val;

  fed_ram #(
    .DEPTH  (MEM_DEPTH),
    .DATA_W (SAMPLE_W),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_raddr),
    .rdata (rdata)
  );

  // Forward the write that lands on the same edge as the read, then multiply
  always_comb begin
    d  = (w_valid && (w_addr == s1_raddr)) ? w_data : rdata;
    pf = PROD_W'(d) * PROD_W'($signed({1'b0, fb_gain}));
    pe = PROD_W'(d) * PROD_W'($signed({1'b0, echo_gain}));
  end

  // Round, mix and saturate
  always_comb begin
    fb_sum    = SUM_W'(s2_x) + SUM_W'(scale_q15(s2_pf));
    echo_diff = SUM_W'(s2_x) - SUM_W'(scale_q15(s2_pe));
    store_val = sat_sample(fb_sum);
    y         = s2_active ? sat_sample(echo_diff) : s2_x;
  end

  assign res.sample_out  = y;
  assign res.out_channel = s2_ch;

  fed_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (res),
    .pop       (out_valid && out_ready),
    .head      (out_data),
    .count     (fifo_count)
  );

  assign out_valid = (fifo_count != '0);

  // Queue space always covers the samples in flight
  a_credit: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (FIFO_CW + 1)'(FIFO_DEPTH))
    else $error("result queue over-committed");

  // A read never targets the entry written by the sample just ahead of it
  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_active && s2_valid && s2_active) |-> (s1_raddr != s2_waddr))
    else $error("unforwarded read of the previous write");

  // No transaction is in flight during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> (!s1_valid && !s2_valid && !w_valid))
    else $error("pipeline active during clearing pass");

  // Write positions stay inside the line
  a_wpos_range: assert property (@(posedge clk) disable iff (rst)
    (32'(wpos[0]) < LINE_DEPTH) && (32'(wpos[1]) < LINE_DEPTH))
    else $error("write position out of range");

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-channel feedback echo delay.
// ----------------------------------------------------------------------------
// Each sample accepted on the input channel runs through a cycle-free copy of
// the echo arithmetic (delay line per channel, Q1.15 gains, 24-bit
// saturation). The copy queues the sample the block should return. Every
// result leaving the block is compared field by field against the oldest
// queued sample. The run starts with hand-picked samples: bypass, unity and
// above-unity gains, half-gain rounding ties, full-scale saturation and the
// one-sample delay. After that come random settings, each with a random
// stream, while the sender works in bursts or steadily and the receiver
// stalls on patterns of its own.
// ----------------------------------------------------------------------------
module testbench;
  import fed_pkg::*;

  localparam int LINE_DEPTH = 32768;
  localparam int CHANNELS   = 2;
  localparam int TARGET_SAMPLES = 1800;

  localparam logic [CFG_IDX_W-1:0]       REG_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] FULL_POS   = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG   = 24'sh800000;
  localparam logic [CFG_W-1:0]           UNITY_GAIN = 16'h8000;
  localparam logic [CFG_W-1:0]           HALF_GAIN  = 16'h4000;
  localparam logic [CFG_W-1:0]           TOP_GAIN   = 16'hFFFF;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;
  typedef enum int {LANES_MIXED, LANES_ALTERNATE, LANES_ONE} lane_mode_t;

  // Echo arithmetic per channel plus the queue of samples still owed
  class echo_checker;
    logic signed [SAMPLE_W-1:0] line_mem [CHANNELS][LINE_DEPTH];
    logic [DLY_W-1:0]           wr_pos [CHANNELS];
    logic [DLY_W-1:0]           delay_len;
    logic [GAIN_W-1:0]          fb_gain;
    logic [GAIN_W-1:0]          mix_gain;
    out_t                       due_samples [$];
    int                         errors;

    function new();
      foreach (line_mem[c, a]) line_mem[c][a] = '0;
      foreach (wr_pos[c]) wr_pos[c] = '0;
      delay_len = '0;
      fb_gain   = '0;
      mix_gain  = '0;
      errors    = 0;
    endfunction

    function logic signed [SAMPLE_W-1:0] clamp(longint v);
      if (v > longint'(FULL_POS)) begin
        return FULL_POS;
      end else if (v < longint'(FULL_NEG)) begin
        return FULL_NEG;
      end
      return v[SAMPLE_W-1:0];
    endfunction

    // Scale by a Q1.15 gain, round half toward plus infinity
    function longint apply_gain(logic signed [SAMPLE_W-1:0] d, logic [GAIN_W-1:0] g);
      longint p;
      p = longint'(d) * longint'(g) + 16384;
      return p >>> 15;
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DELAY:    delay_len = data[DLY_W-1:0];
        REG_FEEDBACK: fb_gain   = data;
        REG_ECHO:     mix_gain  = data;
        default: ;
      endcase
    endfunction

    function void take_sample(in_t s);
      out_t                       r;
      logic [DLY_W-1:0]           rd_pos;
      logic signed [SAMPLE_W-1:0] tap;
      r.out_channel = s.channel;
      r.sample_out  = s.sample_in;
      // Zero delay bypasses the line and leaves all state alone
      if (delay_len != 0) begin
        // Line depth is 2^15, so 15-bit wraparound is the modulo
        rd_pos = wr_pos[s.channel] - delay_len;
        tap    = line_mem[s.channel][rd_pos];
        line_mem[s.channel][wr_pos[s.channel]] =
          clamp(longint'(s.sample_in) + apply_gain(tap, fb_gain));
        wr_pos[s.channel] = wr_pos[s.channel] + 1'b1;
        r.sample_out = clamp(longint'(s.sample_in) - apply_gain(tap, mix_gain));
      end
      due_samples.push_back(r);
    endfunction

    function void check_output(out_t got);
      out_t want;
      if (due_samples.size() == 0) begin
        $error("unexpected result: sample_out %0d out_channel %0d",
               got.sample_out, got.out_channel);
        errors++;
        return;
      end
      want = due_samples.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out mismatch: expected %0d, actual %0d",
               want.sample_out, got.sample_out);
        errors++;
      end
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel mismatch: expected %0d, actual %0d",
               want.out_channel, got.out_channel);
        errors++;
      end
    endfunction

    function int pending();
      return due_samples.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  echo_checker sb;
  int          n_sent = 0;

  feedback_echo_delay #(
    .LINE_DEPTH(LINE_DEPTH),
    .CHANNELS  (CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Check results and pick the next out_ready level
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          tick = 0;
  int          hold_left = 0;
  logic        hold_lvl = 1'b1;
  logic        rdy_next;

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      sb.check_output(out_data);
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(50, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:     rdy_next = 1'b1;
      STALL_RANDOM:   rdy_next = ($urandom_range(0, 2) != 0);
      STALL_PERIODIC: rdy_next = ((tick % 5) < 3);
      default: begin
        if (hold_left == 0) begin
          hold_lvl  = !hold_lvl;
          hold_left = hold_lvl ? $urandom_range(1, 8) : $urandom_range(4, 12);
        end
        hold_left--;
        rdy_next = hold_lvl;
      end
    endcase
    tick++;
    out_ready <= rdy_next;
  end

  function automatic in_t make_sample(logic ch, logic signed [SAMPLE_W-1:0] v);
    in_t s;
    s.channel   = ch;
    s.sample_in = v;
    return s;
  endfunction

  function automatic in_t rand_sample(logic ch);
    logic [31:0]                raw;
    logic signed [SAMPLE_W-1:0] v;
    raw = $urandom();
    case ($urandom_range(0, 9))
      0:       v = raw[0] ? FULL_POS : FULL_NEG;
      1, 2:    v = SAMPLE_W'(int'($urandom_range(0, 200)) - 100);
      3, 4, 5: v = SAMPLE_W'(int'($urandom_range(0, 2097152)) - 1048576);
      default: v = raw[SAMPLE_W-1:0];
    endcase
    return make_sample(ch, v);
  endfunction

  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return UNITY_GAIN;
      2:       return TOP_GAIN;
      3:       return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(0, 32768));
    endcase
  endfunction

  // Hold one transaction until the block takes it
  task automatic send_sample(input in_t s);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_sample(s);
    n_sent++;
  endtask

  // Drop valid and wait for every owed sample
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.configure(idx, data);
  endtask

  // Write the gains first and the delay last, optionally poking the spare index
  task automatic program_regs(input logic [CFG_W-1:0] dly, input logic [CFG_W-1:0] fbk,
                              input logic [CFG_W-1:0] ech, input bit poke_unused);
    if (poke_unused) begin
      put_reg(REG_UNUSED, CFG_W'($urandom()));
    end
    put_reg(REG_FEEDBACK, fbk);
    put_reg(REG_ECHO, ech);
    put_reg(REG_DELAY, dly);
    cfg_we <= 1'b0;
  endtask

  // Stream one random phase, in bursts with random gaps unless steady
  task automatic run_phase(input int n_items, input bit steady);
    int         burst_left;
    int         k;
    lane_mode_t lanes;
    logic       lane;
    logic       ch;
    burst_left = $urandom_range(1, 30);
    lanes      = lane_mode_t'($urandom_range(0, 2));
    lane       = 1'($urandom_range(0, 1));
    for (k = 0; k < n_items; k++) begin
      if (!steady && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
      case (lanes)
        LANES_MIXED:     ch = 1'($urandom_range(0, 1));
        LANES_ALTERNATE: ch = lane ^ k[0];
        default:         ch = lane;
      endcase
      send_sample(rand_sample(ch));
      burst_left--;
    end
    drain();
  endtask

  initial begin
    logic [DLY_W-1:0] dly;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Bypass: the delay write has only the unused top bit set
    program_regs(16'h8000, TOP_GAIN, TOP_GAIN, 1'b1);
    send_sample(make_sample(1'b0, FULL_POS));
    send_sample(make_sample(1'b1, FULL_NEG));
    send_sample(make_sample(1'b0, '0));
    send_sample(make_sample(1'b1, -24'sd1));
    drain();

    // One-sample delay with gains near 2.0: drive both saturation rails
    program_regs(16'd1, TOP_GAIN, TOP_GAIN, 1'b0);
    send_sample(make_sample(1'b0, FULL_POS));
    send_sample(make_sample(1'b0, FULL_POS));
    send_sample(make_sample(1'b0, FULL_NEG));
    send_sample(make_sample(1'b1, FULL_NEG));
    send_sample(make_sample(1'b0, FULL_NEG));
    send_sample(make_sample(1'b1, FULL_POS));
    send_sample(make_sample(1'b0, FULL_NEG));
    send_sample(make_sample(1'b1, 24'sd1));
    drain();

    // Half gains: rounding ties on positive and negative taps
    program_regs(16'd1, HALF_GAIN, HALF_GAIN, 1'b1);
    send_sample(make_sample(1'b0, 24'sd1));
    send_sample(make_sample(1'b0, -24'sd1));
    send_sample(make_sample(1'b0, -24'sd3));
    send_sample(make_sample(1'b0, 24'sd3));
    send_sample(make_sample(1'b0, '0));
    drain();

    // Unity gains, two-sample delay, channels interleaved
    program_regs(16'd2, UNITY_GAIN, UNITY_GAIN, 1'b0);
    send_sample(make_sample(1'b0, 24'sd1000));
    send_sample(make_sample(1'b1, -24'sd1000));
    send_sample(make_sample(1'b0, 24'sd3));
    send_sample(make_sample(1'b1, 24'sd5));
    send_sample(make_sample(1'b0, -24'sd7));
    send_sample(make_sample(1'b1, 24'sd9));
    drain();

    // Random settings, mostly short delays so the feedback path fills up
    while (n_sent < TARGET_SAMPLES) begin
      case ($urandom_range(0, 19))
        0:       dly = '0;
        1:       dly = 15'd32767;
        2:       dly = DLY_W'($urandom_range(100, 32766));
        3, 4:    dly = 15'd1;
        default: dly = DLY_W'($urandom_range(2, 40));
      endcase
      program_regs({1'($urandom_range(0, 1)), dly}, pick_gain(), pick_gain(),
                   ($urandom_range(0, 3) == 0));
      run_phase($urandom_range(40, 160), ($urandom_range(0, 3) == 0));
    end

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
